[rtl/core/gwm_pkg.sv]
// ----------------------------------------------------------------------------
// Glob wildcard matcher package
// Shared constants, pattern character codes and the control/status structs
// that join the matcher controller to its datapath.
// ----------------------------------------------------------------------------
package gwm_pkg;

   // Pattern capacity in bytes.
   localparam int PATTERN_MAX = 32;
   // A pattern position runs from 0 to PATTERN_MAX inclusive.
   localparam int POS_W  = $clog2(PATTERN_MAX + 1);
   localparam int ADDR_W = $clog2(PATTERN_MAX);
   localparam int SET_W  = PATTERN_MAX + 1;

   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUERY  = 8'h3F;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_BYTE   = 2'd2,
      OP_END    = 2'd3
   } gwm_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_pat;
      logic append_pat;
      logic start_byte;
      logic finish_byte;
      logic restart;
      logic emit;
      logic sweep_apply;
      logic class_open;
      logic set_neg;
      logic rd_inc;
      logic pend_load;
      logic add_single;
      logic add_dash;
      logic add_range;
      logic class_done;
      logic end_at_len;
   } gwm_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic at_end;
      logic sweep_end;
      logic act;
      logic ch_lbrack;
      logic ch_bang;
      logic ch_dash;
      logic ch_rbrack;
   } gwm_status_type;

endpackage

[rtl/core/gwm_datapath.sv]
// ----------------------------------------------------------------------------
// Glob wildcard matcher datapath
// Pattern store, active-position sets, bracket class evaluation and the
// result register.
// ----------------------------------------------------------------------------
module gwm_datapath
   import gwm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     data_byte,
   input  gwm_cmd_type    cmd,
   output gwm_status_type status,
   output logic           rsp_matched,
   output logic           rsp_overflow
);

   logic [7:0]       store_ff [PATTERN_MAX];
   logic [POS_W-1:0] len_ff, len_in;
   logic [POS_W-1:0] lead_ff, lead_in;
   logic [POS_W-1:0] ptr_ff, ptr_in;
   logic [POS_W-1:0] rd_ff, rd_in;
   logic             ovf_ff, ovf_in;
   logic [SET_W-1:0] active_ff, active_in;
   logic [SET_W-1:0] nxt_ff, nxt_in;
   logic [SET_W-1:0] restart_set;
   logic [7:0]       byte_ff, byte_in;
   logic [7:0]       pend_ff, pend_in;
   logic             neg_ff, neg_in;
   logic             hit_ff, hit_in;
   logic             rsp_matched_ff, rsp_matched_in;
   logic             rsp_ovf_ff, rsp_ovf_in;
   logic [7:0]       ch;
   logic             full, act_bit, star_c, query_c, lbrack_c, lit_hit;
   logic             hit_now, class_res;
   logic [POS_W-1:0] ptr_inc, end_pos;

   // One read port on the store, addressed by the read pointer.
   assign ch       = store_ff[rd_ff[ADDR_W-1:0]];
   assign full     = (len_ff == POS_W'(PATTERN_MAX));
   assign act_bit  = active_ff[ptr_ff];
   assign star_c   = (ch == CH_STAR);
   assign query_c  = (ch == CH_QUERY);
   assign lbrack_c = (ch == CH_LBRACK);
   assign lit_hit  = !star_c && !query_c && !lbrack_c && (ch == byte_ff);
   assign ptr_inc  = ptr_ff + POS_W'(1);
   assign end_pos  = cmd.end_at_len ? len_ff : (rd_ff + POS_W'(1));

   assign hit_now = hit_ff
                  | (cmd.add_single && (byte_ff == pend_ff))
                  | (cmd.add_dash && (byte_ff == CH_DASH))
                  | (cmd.add_range && (pend_ff <= byte_ff) && (byte_ff <= ch));
   assign class_res = hit_now ^ neg_ff;

   always_comb begin
      lead_in = lead_ff;
      len_in  = len_ff;
      ovf_in  = ovf_ff;
      if (cmd.clear_pat) begin
         lead_in = '0;
         len_in  = '0;
         ovf_in  = 1'b0;
      end else if (cmd.append_pat) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            len_in = len_ff + POS_W'(1);
            // Leading stars close position zero over themselves.
            if ((lead_ff == len_ff) && (data_byte == CH_STAR)) begin
               lead_in = lead_ff + POS_W'(1);
            end
         end
      end
   end

   // Start set: position zero and every position behind a leading star.
   always_comb begin
      for (int i = 0; i < SET_W; i++) begin
         restart_set[i] = (POS_W'(i) <= lead_in);
      end
   end

   always_comb begin
      active_in = active_ff;
      if (cmd.restart) begin
         active_in = restart_set;
      end else if (cmd.finish_byte) begin
         active_in = nxt_ff;
      end
   end

   always_comb begin
      nxt_in = nxt_ff;
      if (cmd.start_byte) begin
         nxt_in = '0;
      end
      if (cmd.sweep_apply) begin
         if (act_bit && star_c) begin
            nxt_in[ptr_ff] = 1'b1;
         end
         // Advance on a match, and close over a star that is now active.
         if ((act_bit && (query_c || lit_hit)) ||
             (star_c && (act_bit || nxt_ff[ptr_ff]))) begin
            nxt_in[ptr_inc] = 1'b1;
         end
      end
      if (cmd.class_done && class_res) begin
         nxt_in[end_pos] = 1'b1;
      end
   end

   always_comb begin
      ptr_in  = ptr_ff;
      rd_in   = rd_ff;
      byte_in = byte_ff;
      if (cmd.start_byte) begin
         ptr_in  = '0;
         rd_in   = '0;
         byte_in = data_byte;
      end
      if (cmd.class_open) begin
         rd_in = ptr_inc;
      end
      if (cmd.rd_inc) begin
         rd_in = rd_ff + POS_W'(1);
      end
      if (cmd.sweep_apply || cmd.class_done) begin
         ptr_in = ptr_inc;
         rd_in  = ptr_inc;
      end
   end

   always_comb begin
      neg_in = neg_ff;
      hit_in = hit_now;
      if (cmd.class_open) begin
         neg_in = 1'b0;
         hit_in = 1'b0;
      end else if (cmd.set_neg) begin
         neg_in = 1'b1;
      end
      pend_in = cmd.pend_load ? ch : pend_ff;
   end

   always_comb begin
      rsp_matched_in = rsp_matched_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      if (cmd.emit) begin
         rsp_matched_in = active_ff[len_ff];
         rsp_ovf_in     = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append_pat && !full) begin
         store_ff[len_ff[ADDR_W-1:0]] <= data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         lead_ff   <= '0;
         ovf_ff    <= 1'b0;
         active_ff <= SET_W'(1);
      end else begin
         len_ff    <= len_in;
         lead_ff   <= lead_in;
         ovf_ff    <= ovf_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_ff         <= nxt_in;
      ptr_ff         <= ptr_in;
      rd_ff          <= rd_in;
      byte_ff        <= byte_in;
      pend_ff        <= pend_in;
      neg_ff         <= neg_in;
      hit_ff         <= hit_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign status.at_end    = (rd_ff == len_ff);
   assign status.sweep_end = (ptr_ff == len_ff);
   assign status.act       = act_bit;
   assign status.ch_lbrack = lbrack_c;
   assign status.ch_bang   = (ch == CH_BANG);
   assign status.ch_dash   = (ch == CH_DASH);
   assign status.ch_rbrack = (ch == CH_RBRACK);

   assign rsp_matched  = rsp_matched_ff;
   assign rsp_overflow = rsp_ovf_ff;

`ifndef SYNTHESIS
   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= POS_W'(PATTERN_MAX))
      else $error("pattern length beyond capacity");

   a_active_below_len: assert property (@(posedge clock) disable iff (reset)
      (active_ff >> len_ff) <= SET_W'(1))
      else $error("active position beyond pattern end");
`endif

endmodule

[rtl/core/gwm_ctrl.sv]
// ----------------------------------------------------------------------------
// Glob wildcard matcher controller
// Sequences commands, the per-byte position sweep and the bracket class scan.
// ----------------------------------------------------------------------------
module gwm_ctrl
   import gwm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  gwm_op_type     req_op,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   input  gwm_status_type status,
   output gwm_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_SWEEP     = 6'b000010,
      ST_CLS_FIRST = 6'b000100,
      ST_CLS_ITEM  = 6'b001000,
      ST_CLS_PEND  = 6'b010000,
      ST_CLS_DASH  = 6'b100000
   } gwm_state_type;

   gwm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   // An end transaction waits only when the result register cannot drain.
   assign req_tready = (state_ff == ST_IDLE) &&
                       ((req_op != OP_END) || !rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_CLEAR: begin
                     cmd.clear_pat = 1'b1;
                     cmd.restart   = 1'b1;
                  end
                  OP_APPEND: begin
                     cmd.append_pat = 1'b1;
                     cmd.restart    = 1'b1;
                  end
                  OP_BYTE: begin
                     cmd.start_byte = 1'b1;
                     state_in       = ST_SWEEP;
                  end
                  OP_END: begin
                     cmd.emit    = 1'b1;
                     cmd.restart = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            if (status.sweep_end) begin
               cmd.finish_byte = 1'b1;
               state_in        = ST_IDLE;
            end else if (status.act && status.ch_lbrack) begin
               cmd.class_open = 1'b1;
               state_in       = ST_CLS_FIRST;
            end else begin
               cmd.sweep_apply = 1'b1;
            end
         end
         ST_CLS_FIRST: begin
            if (status.at_end) begin
               cmd.class_done = 1'b1;
               cmd.end_at_len = 1'b1;
               state_in       = ST_SWEEP;
            end else begin
               if (status.ch_bang) begin
                  cmd.set_neg = 1'b1;
                  cmd.rd_inc  = 1'b1;
               end
               state_in = ST_CLS_ITEM;
            end
         end
         ST_CLS_ITEM: begin
            if (status.at_end) begin
               cmd.class_done = 1'b1;
               cmd.end_at_len = 1'b1;
               state_in       = ST_SWEEP;
            end else if (status.ch_rbrack) begin
               cmd.class_done = 1'b1;
               state_in       = ST_SWEEP;
            end else begin
               cmd.pend_load = 1'b1;
               cmd.rd_inc    = 1'b1;
               state_in      = ST_CLS_PEND;
            end
         end
         ST_CLS_PEND: begin
            if (status.at_end) begin
               cmd.add_single = 1'b1;
               cmd.class_done = 1'b1;
               cmd.end_at_len = 1'b1;
               state_in       = ST_SWEEP;
            end else if (status.ch_dash) begin
               cmd.rd_inc = 1'b1;
               state_in   = ST_CLS_DASH;
            end else if (status.ch_rbrack) begin
               cmd.add_single = 1'b1;
               cmd.class_done = 1'b1;
               state_in       = ST_SWEEP;
            end else begin
               // The pending byte stands alone; this byte opens the next item.
               cmd.add_single = 1'b1;
               cmd.pend_load  = 1'b1;
               cmd.rd_inc     = 1'b1;
            end
         end
         ST_CLS_DASH: begin
            if (status.at_end) begin
               cmd.add_single = 1'b1;
               cmd.add_dash   = 1'b1;
               cmd.class_done = 1'b1;
               cmd.end_at_len = 1'b1;
               state_in       = ST_SWEEP;
            end else if (status.ch_rbrack) begin
               cmd.add_single = 1'b1;
               cmd.add_dash   = 1'b1;
               cmd.class_done = 1'b1;
               state_in       = ST_SWEEP;
            end else begin
               cmd.add_range = 1'b1;
               cmd.rd_inc    = 1'b1;
               state_in      = ST_CLS_ITEM;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input taken while a byte is being processed");

   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_END)) |=> rsp_tvalid)
      else $error("end transaction produced no result");

   a_sweep_returns_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SWEEP) && status.sweep_end) |=> (state_ff == ST_IDLE))
      else $error("sweep did not finish at pattern end");
`endif

endmodule

[rtl/core/glob_wildcard_matcher.sv]
// ----------------------------------------------------------------------------
// Glob wildcard matcher
// Tests streamed strings against a stored shell glob pattern.
// ----------------------------------------------------------------------------
// The block holds one glob pattern of up to PATTERN_MAX bytes and tests
// streamed strings against it. Each input transaction carries a command in
// req_tuser: clear the pattern, append one pattern byte, feed one string byte
// or end the string. Only an end transaction produces a result: matched says
// whether the whole string since the last end, clear or append matched, and
// pattern_overflow says whether append bytes were dropped since the last
// clear because the pattern was full. '*' matches any run including an empty
// one, '?' matches one byte, and '[...]' is a bracket class of single bytes
// and ranges, negated by a leading '!'; an unclosed class runs to the end of
// the pattern. Clear, append and end transactions are handled without a
// sweep. A string byte walks the pattern positions one per cycle, where no
// active position opens a bracket class, through the single read port of
// the pattern store, then moves the next-position set into the active set;
// no new transaction is taken until it is done. An active position that
// opens a bracket class instead scans the class bytes after the '[' and an
// optional '!' through the same read port, up to and including the closing
// ']' or, for an unclosed class, up to the pattern end. The result sits in
// an output register, so new transactions are taken while it waits; only
// an end transaction waits for that register to drain.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher
   import gwm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [1:0] req_tuser,   // [1:0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

   gwm_cmd_type    cmd;
   gwm_status_type status;
   logic           rsp_matched;
   logic           rsp_overflow;

   // The controller decides the sequence of each transaction; the datapath
   // holds the pattern, the active-position sets and the class scan state.
   gwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (gwm_op_type'(req_tuser)),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gwm_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .data_byte    (req_tdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_matched  (rsp_matched),
      .rsp_overflow (rsp_overflow)
   );

   // Result fields packed from the lowest bit up.
   assign rsp_tdata = {6'b000000, rsp_overflow, rsp_matched};

endmodule
